// ----- rtl/nfcs_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// nfcs_pkg
// Shared types, codes and bus-cycle sequence table for the NOR flash
// command sequencer.
// ----------------------------------------------------------------------------
package nfcs_pkg;

	localparam int WORD_ADDR_BITS_DEF   = 26;
	localparam int MAX_BUFFER_WORDS_DEF = 256;
	localparam int COUNT_BITS           = 9;
	localparam int DATA_BITS            = 16;
	localparam int LIMIT_BITS           = 23;
	localparam int CFG_INDEX_BITS       = 1;
	localparam int QUEUE_DEPTH          = 4;
	localparam int QPTR_BITS            = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS            = $clog2(QUEUE_DEPTH + 1);
	localparam int CADDR_BITS           = 12;

	localparam logic [LIMIT_BITS-1:0] TIMEOUT_RESET = 23'd5000000;

	localparam logic [DATA_BITS-1:0] SWAP_KEEP_MASK = 16'hFFFC;
	localparam logic [DATA_BITS-1:0] TOGGLE_MASK    = 16'h0040;

	localparam logic [7:0] CMD_RESET     = 8'hF0;
	localparam logic [7:0] CMD_UNLOCK1   = 8'hAA;
	localparam logic [7:0] CMD_UNLOCK2   = 8'h55;
	localparam logic [7:0] CMD_PPB_ENTRY = 8'hC0;
	localparam logic [7:0] CMD_PPB_PROG  = 8'hA0;
	localparam logic [7:0] CMD_DYB_DATA  = 8'hFF;
	localparam logic [7:0] CMD_ERASE     = 8'h80;
	localparam logic [7:0] CMD_SECTOR    = 8'h30;
	localparam logic [7:0] CMD_WR_BUF    = 8'h25;
	localparam logic [7:0] CMD_CONFIRM   = 8'h29;

	localparam logic [CADDR_BITS-1:0] ADDR_ZERO = 12'h000;
	localparam logic [CADDR_BITS-1:0] ADDR_555  = 12'h555;
	localparam logic [CADDR_BITS-1:0] ADDR_2AA  = 12'h2AA;

	localparam logic [CFG_INDEX_BITS-1:0] REG_BIT_SWAP      = 1'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_TIMEOUT_LIMIT = 1'd1;

	typedef enum logic [2:0] {
		MODE_RESET    = 3'd0,
		MODE_UNLOCK   = 3'd1,
		MODE_ERASE    = 3'd2,
		MODE_BUF_OPEN = 3'd3,
		MODE_BUF_WORD = 3'd4,
		MODE_POLL     = 3'd5
	} mode_t;

	typedef enum logic [2:0] {
		ST_ISSUED    = 3'd0,
		ST_READY     = 3'd1,
		ST_BUSY      = 3'd2,
		ST_TIMEOUT   = 3'd3,
		ST_BAD_COUNT = 3'd4,
		ST_NO_BUFFER = 3'd5
	} stat_t;

	typedef enum logic [2:0] {
		K_RESET,
		K_UNLOCK,
		K_ERASE,
		K_BEGIN,
		K_WORD,
		K_WORD_CONF,
		K_STATUS
	} kind_t;

	// classified command handed from front to back
	typedef struct packed {
		kind_t                kind;
		stat_t                stat;
		logic [DATA_BITS-1:0] data;
	} cmd_t;

	typedef enum logic [1:0] {
		ASEL_CONST,
		ASEL_A,
		ASEL_B
	} asel_t;

	typedef struct packed {
		logic                  write;
		asel_t                 asel;
		logic [CADDR_BITS-1:0] caddr;
		logic                  dsel_field;
		logic [7:0]            cdata;
		logic                  swap;
		logic                  last;
	} seq_t;

	function automatic seq_t mk(input logic write, input asel_t asel,
	                            input logic [CADDR_BITS-1:0] caddr,
	                            input logic dsel_field, input logic [7:0] cdata,
	                            input logic swap, input logic last);
		seq_t s;
		s.write      = write;
		s.asel       = asel;
		s.caddr      = caddr;
		s.dsel_field = dsel_field;
		s.cdata      = cdata;
		s.swap       = swap;
		s.last       = last;
		return s;
	endfunction

	// one bus cycle of a command's expansion
	function automatic seq_t seq_entry(input kind_t kind, input logic [2:0] step);
		seq_t s;
		s = mk(1'b0, ASEL_CONST, ADDR_ZERO, 1'b0, 8'h00, 1'b0, 1'b1);
		unique case (kind)
			K_RESET: s = mk(1'b1, ASEL_CONST, ADDR_ZERO, 1'b0, CMD_RESET, 1'b1, 1'b1);
			K_UNLOCK: begin
				case (step)
					3'd0: s = mk(1'b1, ASEL_CONST, ADDR_555, 1'b0, CMD_UNLOCK1, 1'b1, 1'b0);
					3'd1: s = mk(1'b1, ASEL_CONST, ADDR_2AA, 1'b0, CMD_UNLOCK2, 1'b1, 1'b0);
					3'd2: s = mk(1'b1, ASEL_CONST, ADDR_555, 1'b0, CMD_PPB_ENTRY, 1'b1, 1'b0);
					3'd3: s = mk(1'b1, ASEL_CONST, ADDR_ZERO, 1'b0, CMD_PPB_PROG, 1'b1, 1'b0);
					3'd4: s = mk(1'b1, ASEL_CONST, ADDR_ZERO, 1'b0, CMD_DYB_DATA, 1'b0, 1'b0);
					default: s = mk(1'b1, ASEL_CONST, ADDR_ZERO, 1'b0, CMD_RESET, 1'b1, 1'b1);
				endcase
			end
			K_ERASE: begin
				case (step)
					3'd0: s = mk(1'b1, ASEL_CONST, ADDR_555, 1'b0, CMD_UNLOCK1, 1'b1, 1'b0);
					3'd1: s = mk(1'b1, ASEL_CONST, ADDR_2AA, 1'b0, CMD_UNLOCK2, 1'b1, 1'b0);
					3'd2: s = mk(1'b1, ASEL_CONST, ADDR_555, 1'b0, CMD_ERASE, 1'b1, 1'b0);
					3'd3: s = mk(1'b1, ASEL_CONST, ADDR_555, 1'b0, CMD_UNLOCK1, 1'b1, 1'b0);
					3'd4: s = mk(1'b1, ASEL_CONST, ADDR_2AA, 1'b0, CMD_UNLOCK2, 1'b1, 1'b0);
					default: s = mk(1'b1, ASEL_A, ADDR_ZERO, 1'b0, CMD_SECTOR, 1'b1, 1'b1);
				endcase
			end
			K_BEGIN: begin
				case (step)
					3'd0: s = mk(1'b1, ASEL_CONST, ADDR_555, 1'b0, CMD_UNLOCK1, 1'b1, 1'b0);
					3'd1: s = mk(1'b1, ASEL_CONST, ADDR_2AA, 1'b0, CMD_UNLOCK2, 1'b1, 1'b0);
					3'd2: s = mk(1'b1, ASEL_A, ADDR_ZERO, 1'b0, CMD_WR_BUF, 1'b1, 1'b0);
					default: s = mk(1'b1, ASEL_A, ADDR_ZERO, 1'b1, 8'h00, 1'b1, 1'b1);
				endcase
			end
			K_WORD: s = mk(1'b1, ASEL_A, ADDR_ZERO, 1'b1, 8'h00, 1'b1, 1'b1);
			K_WORD_CONF: begin
				if (step == 3'd0) begin
					s = mk(1'b1, ASEL_A, ADDR_ZERO, 1'b1, 8'h00, 1'b1, 1'b0);
				end else begin
					s = mk(1'b1, ASEL_B, ADDR_ZERO, 1'b0, CMD_CONFIRM, 1'b1, 1'b1);
				end
			end
			K_STATUS: s = mk(1'b0, ASEL_CONST, ADDR_ZERO, 1'b0, 8'h00, 1'b0, 1'b1);
			default: s = mk(1'b0, ASEL_CONST, ADDR_ZERO, 1'b0, 8'h00, 1'b0, 1'b1);
		endcase
		return s;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/nfcs_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// nfcs_front
// Accepts command items, tracks buffer and poll state, and classifies each
// command into a descriptor for the bus-cycle expander.
// ----------------------------------------------------------------------------
module nfcs_front #(
	parameter int WORD_ADDR_BITS   = nfcs_pkg::WORD_ADDR_BITS_DEF,
	parameter int MAX_BUFFER_WORDS = nfcs_pkg::MAX_BUFFER_WORDS_DEF
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   in_valid,
	output logic                                  in_ready,
	input  wire  [2:0]                            mode,
	input  wire  [WORD_ADDR_BITS:0]               byte_address,
	input  wire  [nfcs_pkg::COUNT_BITS-1:0]       word_count,
	input  wire  [nfcs_pkg::DATA_BITS-1:0]        data_word,
	input  wire  [nfcs_pkg::DATA_BITS-1:0]        status_first,
	input  wire  [nfcs_pkg::DATA_BITS-1:0]        status_second,
	input  wire  [nfcs_pkg::LIMIT_BITS-1:0]       timeout_limit,
	input  wire                                   q_full,
	output logic                                  push,
	output nfcs_pkg::cmd_t                        push_cmd,
	output logic [WORD_ADDR_BITS-1:0]             push_addr_a,
	output logic [WORD_ADDR_BITS-1:0]             push_addr_b
);
	import nfcs_pkg::*;

	localparam int AW = WORD_ADDR_BITS;
	localparam logic [COUNT_BITS-1:0] MAX_COUNT = COUNT_BITS'(MAX_BUFFER_WORDS);

	logic [AW-1:0]         program_base_q;
	logic [COUNT_BITS-1:0] words_expected_q;
	logic [COUNT_BITS-1:0] words_loaded_q;
	logic                  buffer_open_q;
	logic [LIMIT_BITS-1:0] poll_remaining_q;

	logic                  accept;
	logic [AW-1:0]         waddr;
	logic [COUNT_BITS-1:0] next_loaded;
	logic                  count_bad;
	logic                  toggle_same;

	assign in_ready    = !q_full;
	assign accept      = in_valid && in_ready;
	assign waddr       = byte_address[AW:1];
	assign next_loaded = words_loaded_q + COUNT_BITS'(1);
	assign count_bad   = (word_count == '0) || (word_count > MAX_COUNT);
	assign toggle_same = ((status_first & TOGGLE_MASK) == (status_second & TOGGLE_MASK));

	always_comb begin
		push          = 1'b0;
		push_cmd.kind = K_STATUS;
		push_cmd.stat = ST_ISSUED;
		push_cmd.data = '0;
		push_addr_a   = waddr;
		push_addr_b   = program_base_q;
		unique case (mode)
			MODE_RESET: begin
				push          = accept;
				push_cmd.kind = K_RESET;
			end
			MODE_UNLOCK: begin
				push          = accept;
				push_cmd.kind = K_UNLOCK;
			end
			MODE_ERASE: begin
				push          = accept;
				push_cmd.kind = K_ERASE;
			end
			MODE_BUF_OPEN: begin
				push = accept;
				if (count_bad) begin
					push_cmd.stat = ST_BAD_COUNT;
				end else begin
					push_cmd.kind = K_BEGIN;
					push_cmd.data = DATA_BITS'(word_count - COUNT_BITS'(1));
				end
			end
			MODE_BUF_WORD: begin
				push        = accept;
				push_addr_a = program_base_q + AW'(words_loaded_q);
				if (!buffer_open_q) begin
					push_cmd.stat = ST_NO_BUFFER;
				end else begin
					push_cmd.kind = (next_loaded >= words_expected_q) ? K_WORD_CONF : K_WORD;
					push_cmd.data = data_word;
				end
			end
			MODE_POLL: begin
				push = accept;
				if (toggle_same) begin
					push_cmd.stat = ST_READY;
				end else if (poll_remaining_q <= LIMIT_BITS'(1)) begin
					push_cmd.kind = K_RESET;
					push_cmd.stat = ST_TIMEOUT;
				end else begin
					push_cmd.stat = ST_BUSY;
				end
			end
			default: push = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			program_base_q   <= '0;
			words_expected_q <= '0;
			words_loaded_q   <= '0;
			buffer_open_q    <= 1'b0;
			poll_remaining_q <= '0;
		end else if (accept) begin
			unique case (mode) inside
				MODE_RESET, MODE_UNLOCK: begin
					buffer_open_q    <= 1'b0;
					poll_remaining_q <= '0;
				end
				MODE_ERASE: begin
					buffer_open_q    <= 1'b0;
					poll_remaining_q <= timeout_limit;
				end
				MODE_BUF_OPEN: begin
					if (count_bad) begin
						buffer_open_q <= 1'b0;
					end else begin
						program_base_q   <= waddr;
						words_expected_q <= word_count;
						words_loaded_q   <= '0;
						buffer_open_q    <= 1'b1;
					end
				end
				MODE_BUF_WORD: begin
					if (buffer_open_q) begin
						words_loaded_q <= next_loaded;
						if (next_loaded >= words_expected_q) begin
							buffer_open_q    <= 1'b0;
							poll_remaining_q <= timeout_limit;
						end
					end
				end
				MODE_POLL: begin
					if (toggle_same || poll_remaining_q <= LIMIT_BITS'(1)) begin
						poll_remaining_q <= '0;
					end else begin
						poll_remaining_q <= poll_remaining_q - LIMIT_BITS'(1);
					end
				end
				default: ;
			endcase
		end
	end

`ifndef SYNTHESIS
	// an open buffer always has words still to load
	a_open_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		buffer_open_q |-> (words_loaded_q < words_expected_q))
		else $error("open buffer already full");
`endif

endmodule
`default_nettype wire

// ----- rtl/nfcs_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// nfcs_queue
// Short descriptor queue between the classifier and the bus-cycle expander.
// ----------------------------------------------------------------------------
module nfcs_queue #(
	parameter int WORD_ADDR_BITS = nfcs_pkg::WORD_ADDR_BITS_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          push,
	input  nfcs_pkg::cmd_t               push_cmd,
	input  wire  [WORD_ADDR_BITS-1:0]    push_addr_a,
	input  wire  [WORD_ADDR_BITS-1:0]    push_addr_b,
	output logic                         full,
	input  wire                          pop,
	output logic                         head_valid,
	output nfcs_pkg::cmd_t               head_cmd,
	output logic [WORD_ADDR_BITS-1:0]    head_addr_a,
	output logic [WORD_ADDR_BITS-1:0]    head_addr_b
);
	import nfcs_pkg::*;

	cmd_t                      cmd_q    [QUEUE_DEPTH];
	logic [WORD_ADDR_BITS-1:0] addr_a_q [QUEUE_DEPTH];
	logic [WORD_ADDR_BITS-1:0] addr_b_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0]      wr_ptr_q;
	logic [QPTR_BITS-1:0]      rd_ptr_q;
	logic [QCNT_BITS-1:0]      count_q;

	assign full        = (count_q == QCNT_BITS'(QUEUE_DEPTH));
	assign head_valid  = (count_q != '0);
	assign head_cmd    = cmd_q[rd_ptr_q];
	assign head_addr_a = addr_a_q[rd_ptr_q];
	assign head_addr_b = addr_b_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			cmd_q[wr_ptr_q]    <= push_cmd;
			addr_a_q[wr_ptr_q] <= push_addr_a;
			addr_b_q[wr_ptr_q] <= push_addr_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + QPTR_BITS'(1);
			if (pop)  rd_ptr_q <= rd_ptr_q + QPTR_BITS'(1);
			if (push && !pop) begin
				count_q <= count_q + QCNT_BITS'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_BITS'(1);
			end
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!head_valid |-> !pop)
		else $error("pop from empty queue");
	a_pointer_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_ptr_q - rd_ptr_q) == count_q[QPTR_BITS-1:0])
		else $error("queue pointers disagree with fill count");
`endif

endmodule
`default_nettype wire

// ----- rtl/nfcs_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// nfcs_back
// Expands each queued command into its bus cycles, one result a cycle while
// the output is not stalled, through a registered output stage.
// ----------------------------------------------------------------------------
module nfcs_back #(
	parameter int WORD_ADDR_BITS = nfcs_pkg::WORD_ADDR_BITS_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              bit_swap,
	input  wire                              head_valid,
	input  nfcs_pkg::cmd_t                   head_cmd,
	input  wire  [WORD_ADDR_BITS-1:0]        head_addr_a,
	input  wire  [WORD_ADDR_BITS-1:0]        head_addr_b,
	output logic                             pop,
	output logic                             out_valid,
	input  wire                              out_ready,
	output logic                             bus_write,
	output logic [WORD_ADDR_BITS-1:0]        bus_address,
	output logic [nfcs_pkg::DATA_BITS-1:0]   bus_data,
	output logic [2:0]                       status,
	output logic                             last
);
	import nfcs_pkg::*;

	localparam int AW = WORD_ADDR_BITS;

	logic [2:0]           step_q;
	logic                 out_valid_q;
	logic                 bus_write_q;
	logic [AW-1:0]        bus_address_q;
	logic [DATA_BITS-1:0] bus_data_q;
	logic [2:0]           status_q;
	logic                 last_q;

	seq_t                 ent;
	logic                 adv;
	logic [AW-1:0]        addr_nx;
	logic [DATA_BITS-1:0] raw_data;
	logic [DATA_BITS-1:0] data_nx;

	assign ent = seq_entry(head_cmd.kind, step_q);
	assign adv = head_valid && (!out_valid_q || out_ready);
	assign pop = adv && ent.last;

	always_comb begin
		case (ent.asel)
			ASEL_A:  addr_nx = head_addr_a;
			ASEL_B:  addr_nx = head_addr_b;
			default: addr_nx = AW'(ent.caddr);
		endcase
		raw_data = ent.dsel_field ? head_cmd.data : DATA_BITS'(ent.cdata);
		if (ent.swap && bit_swap) begin
			data_nx = (raw_data & SWAP_KEEP_MASK) | DATA_BITS'({raw_data[0], raw_data[1]});
		end else begin
			data_nx = raw_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			step_q      <= '0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
			step_q      <= ent.last ? 3'd0 : step_q + 3'd1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// hold the result until the transfer completes
	always_ff @(posedge clk) begin
		if (adv) begin
			bus_write_q   <= ent.write;
			bus_address_q <= addr_nx;
			bus_data_q    <= data_nx;
			status_q      <= head_cmd.stat;
			last_q        <= ent.last;
		end
	end

	assign out_valid   = out_valid_q;
	assign bus_write   = bus_write_q;
	assign bus_address = bus_address_q;
	assign bus_data    = bus_data_q;
	assign status      = status_q;
	assign last        = last_q;

`ifndef SYNTHESIS
	a_step_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (step_q == 3'd0))
		else $error("step counter not cleared after final cycle");
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q < 3'd6)
		else $error("command ran past six bus cycles");
`endif

endmodule
`default_nettype wire

// ----- rtl/nor_flash_command_sequencer_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// nor_flash_command_sequencer_core
// Host-side NOR flash command sequencer: reset, protection unlock, sector
// erase, buffered programming and status polling.
// ----------------------------------------------------------------------------
// A command item is taken on every cycle that the four-entry command queue
// has room; the front end updates buffer and poll state at once. The back
// end emits one result per cycle while a command is queued and the output
// is not stalled. Results per command: one for reset, word, poll and
// rejected commands, two for the last buffer word, four for buffer begin,
// six for unlock and erase. Sustained throughput is set by the bus-cycle
// expander and its output register. The last field marks a command's
// final result. Configuration writes take effect on the next edge.
module nor_flash_command_sequencer_core #(
	parameter int WORD_ADDR_BITS   = nfcs_pkg::WORD_ADDR_BITS_DEF,
	parameter int MAX_BUFFER_WORDS = nfcs_pkg::MAX_BUFFER_WORDS_DEF
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  cfg_we,
	input  wire  [nfcs_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  wire  [nfcs_pkg::LIMIT_BITS-1:0]      cfg_wdata,
	input  wire                                  in_valid,
	output logic                                 in_ready,
	input  wire  [2:0]                           mode,
	input  wire  [WORD_ADDR_BITS:0]              byte_address,
	input  wire  [nfcs_pkg::COUNT_BITS-1:0]      word_count,
	input  wire  [nfcs_pkg::DATA_BITS-1:0]       data_word,
	input  wire  [nfcs_pkg::DATA_BITS-1:0]       status_first,
	input  wire  [nfcs_pkg::DATA_BITS-1:0]       status_second,
	output logic                                 out_valid,
	input  wire                                  out_ready,
	output logic                                 bus_write,
	output logic [WORD_ADDR_BITS-1:0]            bus_address,
	output logic [nfcs_pkg::DATA_BITS-1:0]       bus_data,
	output logic [2:0]                           status,
	output logic                                 last
);
	import nfcs_pkg::*;

	logic                      bit_swap_q;
	logic [LIMIT_BITS-1:0]     timeout_limit_q;

	logic                      q_full;
	logic                      push;
	cmd_t                      push_cmd;
	logic [WORD_ADDR_BITS-1:0] push_addr_a;
	logic [WORD_ADDR_BITS-1:0] push_addr_b;
	logic                      pop;
	logic                      head_valid;
	cmd_t                      head_cmd;
	logic [WORD_ADDR_BITS-1:0] head_addr_a;
	logic [WORD_ADDR_BITS-1:0] head_addr_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_swap_q      <= 1'b0;
			timeout_limit_q <= TIMEOUT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BIT_SWAP:      bit_swap_q      <= cfg_wdata[0];
				REG_TIMEOUT_LIMIT: timeout_limit_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	nfcs_front #(
		.WORD_ADDR_BITS   (WORD_ADDR_BITS),
		.MAX_BUFFER_WORDS (MAX_BUFFER_WORDS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.mode          (mode),
		.byte_address  (byte_address),
		.word_count    (word_count),
		.data_word     (data_word),
		.status_first  (status_first),
		.status_second (status_second),
		.timeout_limit (timeout_limit_q),
		.q_full        (q_full),
		.push          (push),
		.push_cmd      (push_cmd),
		.push_addr_a   (push_addr_a),
		.push_addr_b   (push_addr_b)
	);

	nfcs_queue #(
		.WORD_ADDR_BITS (WORD_ADDR_BITS)
	) u_queue (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.push_cmd    (push_cmd),
		.push_addr_a (push_addr_a),
		.push_addr_b (push_addr_b),
		.full        (q_full),
		.pop         (pop),
		.head_valid  (head_valid),
		.head_cmd    (head_cmd),
		.head_addr_a (head_addr_a),
		.head_addr_b (head_addr_b)
	);

	nfcs_back #(
		.WORD_ADDR_BITS (WORD_ADDR_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.bit_swap    (bit_swap_q),
		.head_valid  (head_valid),
		.head_cmd    (head_cmd),
		.head_addr_a (head_addr_a),
		.head_addr_b (head_addr_b),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.bus_write   (bus_write),
		.bus_address (bus_address),
		.bus_data    (bus_data),
		.status      (status),
		.last        (last)
	);

endmodule
`default_nettype wire

// ----- dv/nfcs_bus_cycle_checker.sv -----
// ----------------------------------------------------------------------------
// nfcs_bus_cycle_checker
// Watches the command and result channels of the NOR flash command sequencer.
// It keeps its own copy of the buffer and poll state and expands every
// accepted command into the bus cycles it should drive. Each result transfer
// is compared field by field with the oldest outstanding cycle.
// ----------------------------------------------------------------------------
module nfcs_bus_cycle_checker #(
	parameter int WORD_ADDR_BITS   = nfcs_pkg::WORD_ADDR_BITS_DEF,
	parameter int MAX_BUFFER_WORDS = nfcs_pkg::MAX_BUFFER_WORDS_DEF
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  cfg_we,
	input  wire  [nfcs_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  wire  [nfcs_pkg::LIMIT_BITS-1:0]      cfg_wdata,
	input  wire                                  in_valid,
	input  wire                                  in_ready,
	input  wire  [2:0]                           mode,
	input  wire  [WORD_ADDR_BITS:0]              byte_address,
	input  wire  [nfcs_pkg::COUNT_BITS-1:0]      word_count,
	input  wire  [nfcs_pkg::DATA_BITS-1:0]       data_word,
	input  wire  [nfcs_pkg::DATA_BITS-1:0]       status_first,
	input  wire  [nfcs_pkg::DATA_BITS-1:0]       status_second,
	input  wire                                  out_valid,
	input  wire                                  out_ready,
	input  wire                                  bus_write,
	input  wire  [WORD_ADDR_BITS-1:0]            bus_address,
	input  wire  [nfcs_pkg::DATA_BITS-1:0]       bus_data,
	input  wire  [2:0]                           status,
	input  wire                                  last,
	output int                                   fail_count,
	output int                                   outstanding,
	output int                                   results_checked
);
	import nfcs_pkg::*;

	localparam int MAX_REPORTS = 40;

	localparam logic [WORD_ADDR_BITS-1:0] WA_ZERO = WORD_ADDR_BITS'(ADDR_ZERO);
	localparam logic [WORD_ADDR_BITS-1:0] WA_555  = WORD_ADDR_BITS'(ADDR_555);
	localparam logic [WORD_ADDR_BITS-1:0] WA_2AA  = WORD_ADDR_BITS'(ADDR_2AA);

	typedef struct packed {
		logic                      write;
		logic [WORD_ADDR_BITS-1:0] addr;
		logic [DATA_BITS-1:0]      data;
		stat_t                     stat;
		logic                      last;
	} bus_cycle_t;

	bus_cycle_t expected_cycles[$];
	bus_cycle_t staged[6];
	int         n_staged;

	// register copies
	logic                      swap_en;
	logic [LIMIT_BITS-1:0]     poll_limit;

	// sequencer state copies
	logic [WORD_ADDR_BITS-1:0] buf_base;
	logic [COUNT_BITS-1:0]     buf_words;
	logic [COUNT_BITS-1:0]     buf_loaded;
	logic                      buf_open;
	logic [LIMIT_BITS-1:0]     polls_left;

	function automatic logic [DATA_BITS-1:0] line_swap(input logic [DATA_BITS-1:0] w);
		return swap_en ? {w[DATA_BITS-1:2], w[0], w[1]} : w;
	endfunction

	task automatic stage(input logic wr, input logic [WORD_ADDR_BITS-1:0] addr,
	                     input logic [DATA_BITS-1:0] data, input stat_t st);
		staged[n_staged] = '{write: wr, addr: addr, data: data, stat: st, last: 1'b0};
		n_staged++;
	endtask

	task automatic stage_cmd(input logic [WORD_ADDR_BITS-1:0] addr, input logic [7:0] cmd);
		stage(1'b1, addr, line_swap({8'h00, cmd}), ST_ISSUED);
	endtask

	task automatic stage_status(input stat_t st);
		stage(1'b0, '0, '0, st);
	endtask

	task automatic predict_command(input logic [2:0] m, input logic [WORD_ADDR_BITS:0] baddr,
	                               input logic [COUNT_BITS-1:0] cnt,
	                               input logic [DATA_BITS-1:0] dw,
	                               input logic [DATA_BITS-1:0] s1,
	                               input logic [DATA_BITS-1:0] s2);
		logic [WORD_ADDR_BITS-1:0] waddr;
		int i;
		n_staged = 0;
		waddr = baddr[WORD_ADDR_BITS:1];
		case (m)
			MODE_RESET: begin
				buf_open = 1'b0;
				polls_left = '0;
				stage_cmd(WA_ZERO, CMD_RESET);
			end
			MODE_UNLOCK: begin
				buf_open = 1'b0;
				polls_left = '0;
				stage_cmd(WA_555, CMD_UNLOCK1);
				stage_cmd(WA_2AA, CMD_UNLOCK2);
				stage_cmd(WA_555, CMD_PPB_ENTRY);
				stage_cmd(WA_ZERO, CMD_PPB_PROG);
				// the DYB data word is never swapped
				stage(1'b1, WA_ZERO, {8'h00, CMD_DYB_DATA}, ST_ISSUED);
				stage_cmd(WA_ZERO, CMD_RESET);
			end
			MODE_ERASE: begin
				buf_open = 1'b0;
				stage_cmd(WA_555, CMD_UNLOCK1);
				stage_cmd(WA_2AA, CMD_UNLOCK2);
				stage_cmd(WA_555, CMD_ERASE);
				stage_cmd(WA_555, CMD_UNLOCK1);
				stage_cmd(WA_2AA, CMD_UNLOCK2);
				stage_cmd(waddr, CMD_SECTOR);
				polls_left = poll_limit;
			end
			MODE_BUF_OPEN: begin
				if (cnt == '0 || cnt > COUNT_BITS'(MAX_BUFFER_WORDS)) begin
					buf_open = 1'b0;
					stage_status(ST_BAD_COUNT);
				end else begin
					buf_base = waddr;
					buf_words = cnt;
					buf_loaded = '0;
					buf_open = 1'b1;
					stage_cmd(WA_555, CMD_UNLOCK1);
					stage_cmd(WA_2AA, CMD_UNLOCK2);
					stage_cmd(buf_base, CMD_WR_BUF);
					stage(1'b1, buf_base, line_swap(DATA_BITS'(cnt - COUNT_BITS'(1))),
					      ST_ISSUED);
				end
			end
			MODE_BUF_WORD: begin
				if (!buf_open) begin
					stage_status(ST_NO_BUFFER);
				end else begin
					// word offsets wrap at the top of the address space
					stage(1'b1, buf_base + WORD_ADDR_BITS'(buf_loaded), line_swap(dw),
					      ST_ISSUED);
					buf_loaded = buf_loaded + COUNT_BITS'(1);
					if (buf_loaded >= buf_words) begin
						stage_cmd(buf_base, CMD_CONFIRM);
						buf_open = 1'b0;
						polls_left = poll_limit;
					end
				end
			end
			MODE_POLL: begin
				if ((s1 & TOGGLE_MASK) == (s2 & TOGGLE_MASK)) begin
					polls_left = '0;
					stage_status(ST_READY);
				end else if (polls_left <= LIMIT_BITS'(1)) begin
					polls_left = '0;
					stage(1'b1, WA_ZERO, line_swap({8'h00, CMD_RESET}), ST_TIMEOUT);
				end else begin
					polls_left = polls_left - LIMIT_BITS'(1);
					stage_status(ST_BUSY);
				end
			end
			default: begin
				// spare modes are dropped without any result
			end
		endcase
		for (i = 0; i < n_staged; i++) begin
			staged[i].last = (i == n_staged - 1);
			expected_cycles.push_back(staged[i]);
		end
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
	                               input logic [31:0] want);
		if (fail_count < MAX_REPORTS) begin
			$display("result %0d: %s is 0x%0h, expected 0x%0h", results_checked, what, got, want);
		end
		fail_count++;
	endtask

	task automatic check_result();
		bus_cycle_t want;
		results_checked++;
		if (expected_cycles.size() == 0) begin
			report_mismatch("unexpected transfer, bus_address", 32'(bus_address), 32'h0);
			return;
		end
		want = expected_cycles.pop_front();
		if (bus_write !== want.write)
			report_mismatch("bus_write", 32'(bus_write), 32'(want.write));
		if (bus_address !== want.addr)
			report_mismatch("bus_address", 32'(bus_address), 32'(want.addr));
		if (bus_data !== want.data)
			report_mismatch("bus_data", 32'(bus_data), 32'(want.data));
		if (status !== want.stat)
			report_mismatch("status", 32'(status), 32'(want.stat));
		if (last !== want.last)
			report_mismatch("last", 32'(last), 32'(want.last));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			swap_en = 1'b0;
			poll_limit = TIMEOUT_RESET;
			buf_base = '0;
			buf_words = '0;
			buf_loaded = '0;
			buf_open = 1'b0;
			polls_left = '0;
			expected_cycles.delete();
			outstanding <= 0;
		end else begin
			// compare before predicting: a command never answers in its own cycle
			if (out_valid && out_ready) begin
				check_result();
			end
			if (cfg_we) begin
				if (cfg_index == REG_BIT_SWAP) begin
					swap_en = cfg_wdata[0];
				end else if (cfg_index == REG_TIMEOUT_LIMIT) begin
					poll_limit = cfg_wdata;
				end
			end
			if (in_valid && in_ready) begin
				predict_command(mode, byte_address, word_count, data_word,
				                status_first, status_second);
			end
			outstanding <= expected_cycles.size();
		end
	end

endmodule

// ----- dv/nor_flash_command_sequencer_core_tb.sv -----
// ----------------------------------------------------------------------------
// nor_flash_command_sequencer_core_tb
// Drives commands into the NOR flash command sequencer: a directed pass over
// every command and corner, then random program, erase and poll sequences
// under several register settings, with random gaps and stalls on both
// channels and one long result stall. Checking lives in nfcs_bus_cycle_checker.
// ----------------------------------------------------------------------------
module nor_flash_command_sequencer_core_tb;
	import nfcs_pkg::*;

	localparam int WORD_ADDR_BITS   = WORD_ADDR_BITS_DEF;
	localparam int MAX_BUFFER_WORDS = MAX_BUFFER_WORDS_DEF;
	localparam int BADDR_BITS       = WORD_ADDR_BITS + 1;
	localparam int HALF_PERIOD      = 10;
	localparam int RESET_CYCLES     = 10;
	localparam int PHASE_ITEMS      = 13;
	localparam int SETTLE_CYCLES    = 16;
	localparam int RX_HOLD_CYCLES   = 400;
	localparam int WATCHDOG_LIMIT   = 5000;

	localparam logic [LIMIT_BITS-1:0] LIMIT_MAX = '1;

	// modes the sequencer leaves unused
	localparam logic [2:0] MODE_SPARE_A = 3'd6;
	localparam logic [2:0] MODE_SPARE_B = 3'd7;

	typedef struct packed {
		logic [2:0]            op;
		logic [BADDR_BITS-1:0] baddr;
		logic [COUNT_BITS-1:0] cnt;
		logic [DATA_BITS-1:0]  dw;
		logic [DATA_BITS-1:0]  s1;
		logic [DATA_BITS-1:0]  s2;
	} command_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_we = 1'b0;
	logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [LIMIT_BITS-1:0]     cfg_wdata = '0;
	logic                      in_valid = 1'b0;
	logic                      in_ready;
	logic [2:0]                mode = '0;
	logic [BADDR_BITS-1:0]     byte_address = '0;
	logic [COUNT_BITS-1:0]     word_count = '0;
	logic [DATA_BITS-1:0]      data_word = '0;
	logic [DATA_BITS-1:0]      status_first = '0;
	logic [DATA_BITS-1:0]      status_second = '0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic                      bus_write;
	logic [WORD_ADDR_BITS-1:0] bus_address;
	logic [DATA_BITS-1:0]      bus_data;
	logic [2:0]                status;
	logic                      last;

	int fail_count;
	int outstanding;
	int results_checked;
	int idle_cycles = 0;
	int items_sent = 0;
	int settings_applied = 0;
	int cmds_per_mode [8];
	bit tx_quiet = 1'b0;
	bit rx_quiet = 1'b0;
	bit rx_hold_req = 1'b0;

	always begin
		clk = 1'b0;
		#HALF_PERIOD;
		clk = 1'b1;
		#HALF_PERIOD;
	end

	nor_flash_command_sequencer_core #(
		.WORD_ADDR_BITS   (WORD_ADDR_BITS),
		.MAX_BUFFER_WORDS (MAX_BUFFER_WORDS)
	) u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.mode          (mode),
		.byte_address  (byte_address),
		.word_count    (word_count),
		.data_word     (data_word),
		.status_first  (status_first),
		.status_second (status_second),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.bus_write     (bus_write),
		.bus_address   (bus_address),
		.bus_data      (bus_data),
		.status        (status),
		.last          (last)
	);

	nfcs_bus_cycle_checker #(
		.WORD_ADDR_BITS   (WORD_ADDR_BITS),
		.MAX_BUFFER_WORDS (MAX_BUFFER_WORDS)
	) u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.mode            (mode),
		.byte_address    (byte_address),
		.word_count      (word_count),
		.data_word       (data_word),
		.status_first    (status_first),
		.status_second   (status_second),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.bus_write       (bus_write),
		.bus_address     (bus_address),
		.bus_data        (bus_data),
		.status          (status),
		.last            (last),
		.fail_count      (fail_count),
		.outstanding     (outstanding),
		.results_checked (results_checked)
	);

	// count cycles with no transfer on either channel
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		wait (idle_cycles >= WATCHDOG_LIMIT);
		$display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
		$display("CHECK FAILED");
		$finish;
	end

	// result side: random stalls, plus one long hold-off when requested
	initial begin : result_sink
		int  stall;
		int  r;
		bit  held;
		held = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (rx_hold_req && !held) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(posedge clk);
			end
			r = $urandom_range(0, 99);
			if (rx_quiet || r < 55) begin
				stall = 0;
			end else if (r < 92) begin
				stall = $urandom_range(1, 3);
			end else begin
				stall = $urandom_range(8, 30);
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	end

	function automatic int pick_gap();
		int r;
		if (tx_quiet) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic command_t random_command(input logic [2:0] op);
		command_t c;
		c.op = op;
		c.baddr = BADDR_BITS'($urandom());
		c.cnt = COUNT_BITS'($urandom());
		c.dw = DATA_BITS'($urandom());
		c.s1 = DATA_BITS'($urandom());
		c.s2 = DATA_BITS'($urandom());
		return c;
	endfunction

	function automatic command_t poll_cmd(input bit ready);
		command_t c;
		c = random_command(MODE_POLL);
		c.s2[6] = ready ? c.s1[6] : ~c.s1[6];
		return c;
	endfunction

	function automatic command_t open_cmd(input int cnt, input logic [BADDR_BITS-1:0] baddr);
		command_t c;
		c = random_command(MODE_BUF_OPEN);
		c.cnt = COUNT_BITS'(cnt);
		c.baddr = baddr;
		return c;
	endfunction

	// called at a rising edge; returns at the edge where the transfer happens
	task automatic issue(input command_t c);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= c.op;
		byte_address <= c.baddr;
		word_count <= c.cnt;
		data_word <= c.dw;
		status_first <= c.s1;
		status_second <= c.s2;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		cmds_per_mode[c.op]++;
		if (c.op <= MODE_POLL) items_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		// spare modes leave nothing to wait for; give the pipe time to empty
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic configure(input logic swap, input logic [LIMIT_BITS-1:0] limit);
		cfg_we <= 1'b1;
		cfg_index <= REG_BIT_SWAP;
		cfg_wdata <= LIMIT_BITS'(swap);
		@(posedge clk);
		cfg_index <= REG_TIMEOUT_LIMIT;
		cfg_wdata <= limit;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		settings_applied++;
	endtask

	task automatic program_buffer(input int cnt, input int words);
		int i;
		issue(open_cmd(cnt, BADDR_BITS'($urandom())));
		for (i = 0; i < words; i++) issue(random_command(MODE_BUF_WORD));
	endtask

	task automatic poll_run();
		int i;
		int busy;
		busy = $urandom_range(0, 6);
		for (i = 0; i < busy; i++) issue(poll_cmd(1'b0));
		if ($urandom_range(0, 4) != 0) issue(poll_cmd(1'b1));
	endtask

	function automatic int pick_count();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80) return $urandom_range(1, 8);
		if (r < 95) return $urandom_range(9, 32);
		return $urandom_range(33, 64);
	endfunction

	task automatic run_phase(input logic swap, input logic [LIMIT_BITS-1:0] limit,
	                         input bit calm, input bit squeeze, input bit full_buffer);
		int start;
		int r;
		int cnt;
		drain();
		configure(swap, limit);
		tx_quiet = calm;
		rx_quiet = calm;
		if (squeeze) rx_hold_req = 1'b1;
		start = items_sent;
		if (full_buffer) begin
			program_buffer(MAX_BUFFER_WORDS, MAX_BUFFER_WORDS);
			poll_run();
		end
		while (items_sent - start < PHASE_ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 45) begin
				cnt = pick_count();
				program_buffer(cnt, cnt);
				poll_run();
			end else if (r < 60) begin
				issue(random_command(MODE_ERASE));
				poll_run();
			end else if (r < 75) begin
				// cut a buffer short and break in with another command
				cnt = pick_count();
				program_buffer(cnt, $urandom_range(0, cnt - 1));
				issue(random_command(3'($urandom_range(MODE_RESET, MODE_BUF_OPEN))));
			end else begin
				issue(random_command(3'($urandom_range(0, 7))));
			end
		end
	endtask

	initial begin : stimulus
		command_t c;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed pass at reset register values
		issue(random_command(MODE_RESET));
		issue(random_command(MODE_UNLOCK));
		c = random_command(MODE_ERASE);
		c.baddr = '1;
		issue(c);
		issue(poll_cmd(1'b0));
		issue(poll_cmd(1'b1));
		issue(poll_cmd(1'b0));
		issue(random_command(MODE_BUF_WORD));
		issue(open_cmd(0, '0));
		issue(open_cmd(MAX_BUFFER_WORDS + 1, '1));
		issue(open_cmd(511, '0));
		// buffer at the top of the address space wraps to offset zero
		issue(open_cmd(3, '1));
		c = random_command(MODE_BUF_WORD);
		c.dw = '1;
		issue(c);
		c.dw = '0;
		issue(c);
		issue(random_command(MODE_BUF_WORD));
		issue(poll_cmd(1'b0));
		issue(poll_cmd(1'b1));
		issue(open_cmd(MAX_BUFFER_WORDS, '0));
		issue(random_command(MODE_BUF_WORD));
		issue(open_cmd(1, BADDR_BITS'($urandom())));
		issue(random_command(MODE_BUF_WORD));
		issue(open_cmd(2, BADDR_BITS'($urandom())));
		issue(random_command(MODE_BUF_WORD));
		issue(random_command(MODE_RESET));
		issue(random_command(MODE_BUF_WORD));
		issue(random_command(MODE_SPARE_A));
		issue(random_command(MODE_SPARE_B));

		run_phase(1'b1, LIMIT_BITS'(1), 1'b0, 1'b0, 1'b0);
		run_phase(1'b0, '0, 1'b0, 1'b0, 1'b0);
		run_phase(1'b1, LIMIT_BITS'(2), 1'b1, 1'b1, 1'b0);
		run_phase(1'b0, LIMIT_MAX, 1'b0, 1'b0, 1'b1);
		run_phase(1'b1, LIMIT_BITS'($urandom_range(3, 8)), 1'b0, 1'b0, 1'b0);
		run_phase(1'b0, LIMIT_BITS'(3), 1'b1, 1'b0, 1'b0);
		run_phase(1'b1, TIMEOUT_RESET, 1'b0, 1'b0, 1'b0);
		drain();

		$display("commands: %0d reset %0d unlock %0d erase %0d begin %0d word %0d poll %0d spare",
		         cmds_per_mode[MODE_RESET], cmds_per_mode[MODE_UNLOCK],
		         cmds_per_mode[MODE_ERASE], cmds_per_mode[MODE_BUF_OPEN],
		         cmds_per_mode[MODE_BUF_WORD], cmds_per_mode[MODE_POLL],
		         cmds_per_mode[MODE_SPARE_A] + cmds_per_mode[MODE_SPARE_B]);
		$display("%0d results compared over %0d register settings, %0d mismatches",
		         results_checked, settings_applied, fail_count);
		if (fail_count == 0 && outstanding == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
